@@ src/mrrle_pkg.sv @@
// Shared types and constants of the mask row run-length encoder.
`default_nettype none

package mrrle_pkg;

    localparam int VALUE_W     = 8;
    localparam int SEG_START_W = 12;
    localparam int SEG_ROW_W   = 12;
    localparam int SEG_LEN_W   = 13;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK_WIDTH  = 1'b0,
        CFG_MASK_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [SEG_START_W-1:0] start;
        logic [SEG_ROW_W-1:0]   row;
        logic [SEG_LEN_W-1:0]   length;
        logic [VALUE_W-1:0]     value;
        logic                   last;
    } seg_t;

    typedef struct packed {
        logic push_a;
        logic push_b;
        seg_t seg_a;
        seg_t seg_b;
    } seg_push_t;

endpackage

`default_nettype wire

@@ src/mrrle_if.sv @@
// Handshake interfaces for the pixel input and the segment output channels.
`default_nettype none

interface mrrle_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] mask_value;

    modport source (output valid, output mask_value, input ready);
    modport sink (input valid, input mask_value, output ready);
endinterface

interface mrrle_seg_if;
    logic        valid;
    logic        ready;
    logic [11:0] seg_start;
    logic [11:0] seg_row;
    logic [12:0] seg_length;
    logic [7:0]  seg_value;
    logic        seg_last;

    modport source (output valid, output seg_start, output seg_row, output seg_length,
                    output seg_value, output seg_last, input ready);
    modport sink (input valid, input seg_start, input seg_row, input seg_length,
                  input seg_value, input seg_last, output ready);
endinterface

`default_nettype wire

@@ src/mrrle_core.sv @@
// Run tracking state and segment formation for one pixel per step.
`default_nettype none

module mrrle_core
    import mrrle_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [VALUE_W-1:0] pixel,
    input  wire logic [CFG_W-1:0]   width_cfg,
    input  wire logic [CFG_W-1:0]   height_cfg,
    output seg_push_t               push
);

    // The configuration registers cannot exceed their field range.
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int EFF_W   = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
    localparam int EFF_H   = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
    localparam int COL_W   = $clog2(EFF_W);
    localparam int ROW_W   = (EFF_H > 1) ? $clog2(EFF_H) : 1;
    localparam int RUN_W   = $clog2(EFF_W + 1);
    localparam int CALC_W  = CFG_W + 1;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [VALUE_W-1:0] prev_reg, prev_next;

    logic [CFG_W-1:0]   w_eff;
    logic [CFG_W-1:0]   h_eff;
    logic               close_run;
    logic [RUN_W-1:0]   run_kept;
    logic [RUN_W-1:0]   run_grown;
    logic               row_end;
    logic               row_wrap;
    logic               flush;
    seg_t               seg_close;
    seg_t               seg_flush;

    always_comb
    begin
        if (width_cfg == '0)
            w_eff = CFG_W'(1);
        else if (width_cfg > CFG_W'(EFF_W))
            w_eff = CFG_W'(EFF_W);
        else
            w_eff = width_cfg;

        if (height_cfg == '0)
            h_eff = CFG_W'(1);
        else if (height_cfg > CFG_W'(EFF_H))
            h_eff = CFG_W'(EFF_H);
        else
            h_eff = height_cfg;
    end

    always_comb
    begin
        close_run = (run_reg != '0) && (pixel != prev_reg);
        run_kept  = close_run ? '0 : run_reg;
        run_grown = RUN_W'(run_kept + RUN_W'(pixel != '0));
        row_end   = (CALC_W'(col_reg) + CALC_W'(1)) >= CALC_W'(w_eff);
        row_wrap  = (CALC_W'(row_reg) + CALC_W'(1)) >= CALC_W'(h_eff);
        flush     = row_end && (run_grown != '0);

        seg_close.start  = SEG_START_W'(CALC_W'(col_reg) - CALC_W'(run_reg));
        seg_close.row    = SEG_ROW_W'(row_reg);
        seg_close.length = SEG_LEN_W'(run_reg);
        seg_close.value  = prev_reg;
        seg_close.last   = !flush;

        seg_flush.start  = SEG_START_W'(CALC_W'(col_reg) + CALC_W'(1) - CALC_W'(run_grown));
        seg_flush.row    = SEG_ROW_W'(row_reg);
        seg_flush.length = SEG_LEN_W'(run_grown);
        seg_flush.value  = pixel;
        seg_flush.last   = 1'b1;

        // The closed run always goes out ahead of the row-end flush.
        push.push_a = step && (close_run || flush);
        push.push_b = step && close_run && flush;
        push.seg_a  = close_run ? seg_close : seg_flush;
        push.seg_b  = seg_flush;

        if (row_end)
        begin
            col_next  = '0;
            run_next  = '0;
            prev_next = '0;
            row_next  = row_wrap ? '0 : ROW_W'(row_reg + 1'b1);
        end
        else
        begin
            col_next  = COL_W'(col_reg + 1'b1);
            run_next  = run_grown;
            prev_next = pixel;
            row_next  = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            run_reg  <= '0;
            prev_reg <= '0;
        end
        else if (step)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            run_reg  <= run_next;
            prev_reg <= prev_next;
        end
    end

endmodule

`default_nettype wire

@@ src/mrrle_seg_fifo.sv @@
// Four-entry segment queue; takes up to two segments, gives one per cycle on pop.
`default_nettype none

module mrrle_seg_fifo
    import mrrle_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire seg_push_t push,
    input  wire logic      pop,
    output logic           room2,
    output logic           not_empty,
    output seg_t           head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    seg_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_push;
    logic             do_pop;

    always_comb
    begin
        not_empty   = count_reg != '0;
        room2       = count_reg <= CNT_W'(DEPTH - 2);
        head        = mem_reg[rd_ptr_reg];
        do_pop      = pop && not_empty;
        n_push      = CNT_W'(push.push_a) + CNT_W'(push.push_b);
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(n_push));
        rd_ptr_next = PTR_W'(rd_ptr_reg + PTR_W'(do_pop));
        count_next  = CNT_W'(count_reg + n_push - CNT_W'(do_pop));
    end

    always_ff @(posedge clk)
    begin
        if (push.push_a)
            mem_reg[wr_ptr_reg] <= push.seg_a;
        if (push.push_b)
            mem_reg[PTR_W'(wr_ptr_reg + 1'b1)] <= push.seg_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Fill level never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("segment queue overfilled");

    // Segments are only pushed while the queue reports room for two.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.push_a |-> count_reg <= CNT_W'(DEPTH - 2))
        else $error("segment pushed without room");

    // A second segment never comes without a first one.
    assert property (@(posedge clk) disable iff (!rst_n) push.push_b |-> push.push_a)
        else $error("second segment without first");

    // Pointers stay consistent with the fill level.
    assert property (@(posedge clk) disable iff (!rst_n)
        PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg))
        else $error("queue pointers and count disagree");

endmodule

`default_nettype wire

@@ src/mask_row_run_length_encoder_top.sv @@
// Top level of the mask row run-length encoder.
//
// Mask bytes enter on the pix channel in raster order, one word per pixel,
// left to right along a row and rows top to bottom. Each maximal run of equal
// nonzero bytes within a row leaves on the seg channel as one word carrying
// its start column, row, length and value; zero bytes produce nothing. One
// pixel can close two runs (a value change plus the row-end flush); the later
// word then has seg_last set and the earlier one has it clear.
// Row width and mask height are written through cfg_we/cfg_index/cfg_data
// while the block is idle, a rule the user must keep as the block does not
// enforce it; both reset to 1, zero reads as 1, and values above MAX_WIDTH /
// MAX_HEIGHT saturate. A pixel waits in the input register until the queue
// has room for two segments, is evaluated in a single pass, and its segments
// go into the queue. Throughput is one pixel per cycle; the four-entry
// segment queue absorbs the occasional double segment, so the input only
// pauses when the queue holds more than two words, i.e. when the receiver
// stalls. Reset clears the column, row and run state and empties the queue.
// While the receiver holds ready low the queue fills and pix.ready then
// drops; no word is lost or repeated.
`default_nettype none

module mask_row_run_length_encoder_top
    import mrrle_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    mrrle_pix_if.sink                 pix,
    mrrle_seg_if.source               seg,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic               in_valid_reg;
    logic [VALUE_W-1:0] in_value_reg;
    logic               advance;
    logic               room2;
    logic               not_empty;
    seg_t               head;
    seg_push_t          push;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MASK_WIDTH:  width_reg  <= cfg_data;
                CFG_MASK_HEIGHT: height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // The input register moves into the core whenever the queue can take two
    // segments, which is the most a single pixel can produce.
    assign advance   = in_valid_reg && room2;
    assign pix.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (pix.ready)
            in_valid_reg <= pix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix.ready && pix.valid)
            in_value_reg <= pix.mask_value;
    end

    mrrle_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .pixel      (in_value_reg),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .push       (push)
    );

    mrrle_seg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (seg.ready),
        .room2     (room2),
        .not_empty (not_empty),
        .head      (head)
    );

    assign seg.valid      = not_empty;
    assign seg.seg_start  = head.start;
    assign seg.seg_row    = head.row;
    assign seg.seg_length = head.length;
    assign seg.seg_value  = head.value;
    assign seg.seg_last   = head.last;

endmodule

`default_nettype wire
